/* rtl/core/dtpg_pkg.sv */
// Shared types, constants and the bar palette for the display test pattern generator.
`default_nettype none
package dtpg_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int DIM_W     = 11;
  localparam int COORD_W   = 10;
  localparam int COLOR_W   = 16;
  localparam int STRIDE_W  = 12;
  localparam int ADDR_W    = 21;
  localparam int PROD_W    = COORD_W + STRIDE_W;
  localparam int DIV_NUM_W = 18;
  localparam int DIV_DEN_W = 10;
  localparam int DIV_REM_W = DIV_DEN_W;
  localparam int DIV_CNT_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int BAR_IDX_W = 3;

  localparam logic [1:0] MODE_SOLID    = 2'd0;
  localparam logic [1:0] MODE_GRADIENT = 2'd1;
  localparam logic [1:0] MODE_BARS     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOLID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC0,
    ST_WAIT0,
    ST_CALC1,
    ST_WAIT1,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DIV_RED,
    DIV_GREEN,
    DIV_BAR
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_first;
    logic     cap_second;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       div_busy;
    logic       div_done;
    logic       out_free;
  } dp_sts_t;

  function automatic logic [COLOR_W-1:0] bar_color(input logic [BAR_IDX_W-1:0] idx);
    logic [COLOR_W-1:0] c;
    case (idx)
      3'd0:    c = 16'hf800;
      3'd1:    c = 16'h07e0;
      3'd2:    c = 16'h001f;
      3'd3:    c = 16'hffe0;
      3'd4:    c = 16'hf81f;
      3'd5:    c = 16'h07ff;
      3'd6:    c = 16'hffff;
      default: c = 16'h0000;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/dtpg_div.sv */
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none
module dtpg_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [dtpg_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [dtpg_pkg::DIV_DEN_W-1:0] den,
  output logic                                busy,
  output logic                                done,
  output logic [dtpg_pkg::DIV_NUM_W-1:0]      quo
);
  import dtpg_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_NUM_W-1:0] num_r, num_nxt;
  logic [DIV_DEN_W-1:0] den_r, den_nxt;
  logic [DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_REM_W:0]   rem_sh;
  logic [DIV_REM_W:0]   rem_diff;
  logic                 q_bit;

  always_comb begin
    rem_sh   = {rem_r, num_r[DIV_NUM_W-1]};
    rem_diff = rem_sh - {1'b0, den_r};
    q_bit    = (rem_sh >= {1'b0, den_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[DIV_NUM_W-2:0], q_bit};
      rem_nxt = q_bit ? rem_diff[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = num_r;

endmodule
`default_nettype wire

/* rtl/core/dtpg_dp.sv */
// Datapath: configuration, scan counters, divider operands, color and address, output beat.
`default_nettype none
module dtpg_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dtpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dtpg_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                           in_restart,
  input  wire dtpg_pkg::ctrl_cmd_t            cmd,
  output dtpg_pkg::dp_sts_t                   sts,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [63:0]                         out_tdata,
  output logic                                out_tlast
);
  import dtpg_pkg::*;

  logic [1:0]          mode_r;
  logic [COLOR_W-1:0]  solid_r;
  logic [DIM_W-1:0]    fw_r, fh_r;
  logic [STRIDE_W-1:0] stride_r;

  logic [COORD_W-1:0]  col_r, col_nxt, row_r, row_nxt;
  logic [COORD_W-1:0]  x_r, x_nxt, y_r, y_nxt;
  logic [DIV_NUM_W-1:0] res0_r, res1_r;

  logic                out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0]  color_out_r;
  logic [COORD_W-1:0]  col_out_r, row_out_r;
  logic [ADDR_W-1:0]   addr_out_r;
  logic                last_out_r;

  logic [DIM_W-1:0]    w, h, w_m1, h_m1;
  logic [DIM_W-1:0]    col_pre, row_pre, col_a, row_a, row_b, x_inc, row_inc;
  logic [7:0]          bw;
  logic [DIV_NUM_W-1:0] div_num, x_ext, y_ext;
  logic [DIV_DEN_W-1:0] div_den;
  logic                div_busy, div_done;
  logic [DIV_NUM_W-1:0] div_quo;
  logic [7:0]          red, green, blue;
  logic [BAR_IDX_W-1:0] bar_idx;
  logic [COLOR_W-1:0]  color;
  logic [PROD_W-1:0]   prod, addr_full;
  logic                last;

  // clamp dimensions to 1..MAX_DIM
  always_comb begin
    if (fw_r == '0)                  w = DIM_W'(1);
    else if (fw_r > DIM_W'(MAX_DIM)) w = DIM_W'(MAX_DIM);
    else                             w = fw_r;
    if (fh_r == '0)                  h = DIM_W'(1);
    else if (fh_r > DIM_W'(MAX_DIM)) h = DIM_W'(MAX_DIM);
    else                             h = fh_r;
    w_m1 = w - 1'b1;
    h_m1 = h - 1'b1;
    bw   = (w[DIM_W-1:3] == '0) ? 8'd1 : w[DIM_W-1:3];
  end

  // scan position for this pixel, then advance
  always_comb begin
    col_pre = in_restart ? '0 : {1'b0, col_r};
    row_pre = in_restart ? '0 : {1'b0, row_r};
    if (col_pre >= w) begin
      col_a = '0;
      row_a = row_pre + 1'b1;
    end else begin
      col_a = col_pre;
      row_a = row_pre;
    end
    row_b   = (row_a >= h) ? '0 : row_a;
    x_inc   = col_a + 1'b1;
    row_inc = row_b + 1'b1;
    x_nxt   = x_r;
    y_nxt   = y_r;
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.load) begin
      x_nxt = col_a[COORD_W-1:0];
      y_nxt = row_b[COORD_W-1:0];
      if (x_inc >= w) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h) ? '0 : row_inc[COORD_W-1:0];
      end else begin
        col_nxt = x_inc[COORD_W-1:0];
        row_nxt = row_b[COORD_W-1:0];
      end
    end
  end

  // divider operands: ramp is pos*255/(dim-1), bar index is x/bw
  always_comb begin
    x_ext = DIV_NUM_W'(x_r);
    y_ext = DIV_NUM_W'(y_r);
    case (cmd.div_sel)
      DIV_RED: begin
        div_num = (x_ext << 8) - x_ext;
        div_den = w_m1[DIV_DEN_W-1:0];
      end
      DIV_GREEN: begin
        div_num = (y_ext << 8) - y_ext;
        div_den = h_m1[DIV_DEN_W-1:0];
      end
      default: begin
        div_num = x_ext;
        div_den = DIV_DEN_W'(bw);
      end
    endcase
  end

  dtpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // color, address and frame end
  always_comb begin
    if (w == DIM_W'(1))       red = 8'd0;
    else if (res0_r > 18'd255) red = 8'hff;
    else                       red = res0_r[7:0];
    if (h == DIM_W'(1))       green = 8'd0;
    else if (res1_r > 18'd255) green = 8'hff;
    else                       green = res1_r[7:0];
    blue    = 8'hff - red;
    bar_idx = (res0_r > 18'd7) ? 3'd7 : res0_r[BAR_IDX_W-1:0];
    case (mode_r)
      MODE_GRADIENT: color = {red[7:3], green[7:2], blue[7:3]};
      MODE_BARS:     color = bar_color(bar_idx);
      default:       color = solid_r;
    endcase
    prod      = y_r * stride_r;
    addr_full = prod + PROD_W'(x_r);
    last      = ({1'b0, x_r} == w_m1) && ({1'b0, y_r} == h_m1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit)        out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SOLID;
      solid_r     <= 16'h001f;
      fw_r        <= 11'd320;
      fh_r        <= 11'd240;
      stride_r    <= 12'd320;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:   mode_r   <= cfg_wdata[1:0];
          REG_SOLID:  solid_r  <= cfg_wdata;
          REG_WIDTH:  fw_r     <= cfg_wdata[DIM_W-1:0];
          REG_HEIGHT: fh_r     <= cfg_wdata[DIM_W-1:0];
          REG_STRIDE: stride_r <= cfg_wdata[STRIDE_W-1:0];
          default:    ;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
    if (cmd.cap_first)  res0_r <= div_quo;
    if (cmd.cap_second) res1_r <= div_quo;
    if (cmd.emit) begin
      color_out_r <= color;
      col_out_r   <= x_r;
      row_out_r   <= y_r;
      addr_out_r  <= addr_full[ADDR_W-1:0];
      last_out_r  <= last;
    end
  end

  assign sts.mode     = mode_r;
  assign sts.div_busy = div_busy;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, addr_out_r, row_out_r, col_out_r, color_out_r};
  assign out_tlast  = last_out_r;

endmodule
`default_nettype wire

/* rtl/core/dtpg_ctrl.sv */
// Controller state machine: accept a request, sequence the divisions, hand off the beat.
`default_nettype none
module dtpg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire dtpg_pkg::dp_sts_t   sts,
  output dtpg_pkg::ctrl_cmd_t      cmd
);
  import dtpg_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.div_sel    = DIV_BAR;
    in_tready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CALC0;
        end
      end
      ST_CALC0: begin
        case (sts.mode)
          MODE_GRADIENT: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_RED;
            state_nxt     = ST_WAIT0;
          end
          MODE_BARS: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_BAR;
            state_nxt     = ST_WAIT0;
          end
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_WAIT0: begin
        if (sts.div_done) begin
          cmd.cap_first = 1'b1;
          state_nxt     = (sts.mode == MODE_GRADIENT) ? ST_CALC1 : ST_EMIT;
        end
      end
      ST_CALC1: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_GREEN;
        state_nxt     = ST_WAIT1;
      end
      ST_WAIT1: begin
        if (sts.div_done) begin
          cmd.cap_second = 1'b1;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold until the output register can take the beat
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !sts.div_busy)
    else $error("divider started while busy");
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_WAIT0 || state_r == ST_WAIT1))
    else $error("divider finished outside a wait state");
  a_load_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_tready)
    else $error("request taken while previous pixel in progress");
`endif

endmodule
`default_nettype wire

/* rtl/core/display_test_pattern_generator.sv */
// A request beat is accepted only while idle; solid mode emits the result beat without division,
// bar mode runs the 18-step serial divider once and gradient mode runs it twice. A new request
// is taken in the cycle after the previous result enters the output register.
// Synchronous active-low reset clears the scan to (0,0) and loads the default registers.
`default_nettype none
module display_test_pattern_generator (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dtpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dtpg_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [0] restart, [7:1] zero
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [15:0] pixel_color, [25:16] column, [35:26] row, [56:36] word_address, [63:57] zero
  output logic [63:0]                         out_tdata,
  output logic                                out_tlast   // last_of_frame
);
  import dtpg_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  dtpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dtpg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_restart (in_tdata[0]),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

/* tb/display_test_pattern_generator_tb.sv */
// Self-checking testbench for the RGB565 display test pattern generator.
module display_test_pattern_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dtpg_pkg::*;

  // pattern_mode code with no pattern of its own; the block falls back to solid
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // bar palette, bar 0 in the lowest 16 bits
  localparam logic [8*COLOR_W-1:0] BAR_RGB = {
    16'h0000, 16'hffff, 16'h07ff, 16'hf81f, 16'hffe0, 16'h001f, 16'h07e0, 16'hf800
  };

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [ADDR_W-1:0]  addr;
    logic               last;
  } pixel_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [63:0]          out_tdata;
  logic                 out_tlast;

  // register copies and scan position of the pixel predictor
  logic [1:0]          mode_sh = MODE_SOLID;
  logic [COLOR_W-1:0]  solid_sh = 16'h001f;
  logic [DIM_W-1:0]    width_sh = 11'd320;
  logic [DIM_W-1:0]    height_sh = 11'd240;
  logic [STRIDE_W-1:0] stride_sh = 12'd320;
  logic [COORD_W-1:0]  col_cnt = '0;
  logic [COORD_W-1:0]  row_cnt = '0;

  bit     request_q[$];
  pixel_t pixel_q[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_req = 0;
  int     hold_seen = 0;
  int     hold_left = 0;

  display_test_pattern_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [0] restart, [7:1] zero
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    // [15:0] pixel_color, [25:16] column, [35:26] row, [56:36] word_address, [63:57] zero
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)    // last_of_frame
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int unsigned eff_dim(logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned ramp8(int unsigned pos, int unsigned dim);
    if (dim < 2) return 0;
    return pos * 255 / (dim - 1);
  endfunction

  // advance the scan by one pixel and return what the block must emit for it
  function automatic pixel_t next_pixel(bit restart);
    int unsigned w, h, x, y, r, g, bw, bar, a;
    pixel_t p;
    w = eff_dim(width_sh);
    h = eff_dim(height_sh);
    x = restart ? 0 : col_cnt;
    y = restart ? 0 : row_cnt;
    // frame may have shrunk under the counters
    if (x >= w) begin
      x = 0;
      y++;
    end
    if (y >= h) y = 0;
    case (mode_sh)
      MODE_GRADIENT: begin
        r = ramp8(x, w);
        g = ramp8(y, h);
        // blue is 255 - red, i.e. the inverted red bits
        p.color = {r[7:3], g[7:2], ~r[7:3]};
      end
      MODE_BARS: begin
        bw = w / 8;
        if (bw == 0) bw = 1;
        bar = x / bw;
        if (bar > 7) bar = 7;
        p.color = BAR_RGB[bar*COLOR_W +: COLOR_W];
      end
      default: p.color = solid_sh;
    endcase
    a = y * stride_sh + x;
    p.column = x[COORD_W-1:0];
    p.row = y[COORD_W-1:0];
    p.addr = a[ADDR_W-1:0];
    p.last = (x == w - 1) && (y == h - 1);
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    col_cnt = x[COORD_W-1:0];
    row_cnt = y[COORD_W-1:0];
    return p;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_pixel;
    pixel_t e;
    if (pixel_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected pixel beat expected none actual %h last %b",
               $time, out_tdata, out_tlast);
    end else begin
      e = pixel_q.pop_front();
      check_field("pixel_color", e.color, out_tdata[15:0]);
      check_field("column", e.column, out_tdata[25:16]);
      check_field("row", e.row, out_tdata[35:26]);
      check_field("word_address", e.addr, out_tdata[56:36]);
      check_field("padding", 0, out_tdata[63:57]);
      check_field("last_of_frame", e.last, out_tlast);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) pixel_q.push_back(next_pixel(in_tdata[0]));
      if (!in_tvalid || in_tready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata <= {7'b0, request_q.pop_front()};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // pixel monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_pixel();
      out_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, started by bumping hold_req
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 400;
    end
  end

  task automatic set_idling(idle_kind_t kind);
    @(negedge clk);
    send_idle_pct = (kind == IDLE_SENDER || kind == IDLE_BOTH) ?
                    ((kind == IDLE_BOTH) ? 22 : 87) : 0;
    recv_stall_pct = (kind == IDLE_RECEIVER || kind == IDLE_BOTH) ?
                     ((kind == IDLE_BOTH) ? 22 : 87) : 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DAT_W-1:0];
    case (idx)
      REG_MODE:   mode_sh = val[1:0];
      REG_SOLID:  solid_sh = val[COLOR_W-1:0];
      REG_WIDTH:  width_sh = val[DIM_W-1:0];
      REG_HEIGHT: height_sh = val[DIM_W-1:0];
      REG_STRIDE: stride_sh = val[STRIDE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(logic [1:0] mode, int unsigned solid, int unsigned w,
                           int unsigned h, int unsigned stride);
    write_reg(REG_MODE, mode);
    write_reg(REG_SOLID, solid);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_STRIDE, stride);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pixels(int n, int restart_pct);
    @(negedge clk);
    for (int i = 0; i < n; i++) request_q.push_back($urandom_range(99) < restart_pct);
  endtask

  task automatic wait_drained;
    do @(negedge clk); while (request_q.size() != 0 || in_tvalid || pixel_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned w, h, n, frame_px;
    int small_count;
    int phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    set_idling(IDLE_NONE);

    // reset defaults, then a restart
    queue_pixels(1, 0);
    queue_pixels(1, 100);
    wait_drained();
    // 1x1 gradient: both ramps zero, every pixel is the last one
    set_frame(MODE_GRADIENT, 16'h0000, 1, 1, 0);
    queue_pixels(2, 0);
    wait_drained();
    // zero dimensions count as one; unused mode acts as solid
    set_frame(MODE_UNUSED, 16'hffff, 0, 0, 4095);
    queue_pixels(2, 0);
    wait_drained();
    // narrow bars: width 12 gives bar width 1, columns past 7 clamp to the last bar
    set_frame(MODE_BARS, 16'h1234, 12, 2, 12);
    queue_pixels(12, 0);
    queue_pixels(1, 100);
    wait_drained();
    // oversized dimensions clamp to the maximum
    set_frame(MODE_GRADIENT, 16'h8421, 2047, 2047, 2048);
    queue_pixels(1, 100);
    queue_pixels(2, 0);
    wait_drained();
    // scan sits at column 3; shrinking wraps column and row before the pixel
    set_frame(MODE_SOLID, 16'h0000, 2, 1, 1);
    queue_pixels(1, 0);
    wait_drained();

    // mostly small frames, scanned whole, larger ones only in part; counters carried across settings
    small_count = 0;
    phase = 0;
    while (small_count < 250) begin
      set_idling(idle_kind_t'(phase % 4));
      w = ($urandom_range(9) < 7) ? $urandom_range(1, 16) : $urandom_range(2047);
      h = ($urandom_range(9) < 8) ? $urandom_range(1, 8) : $urandom_range(2047);
      set_frame(2'($urandom_range(3)), $urandom, w, h, $urandom_range(4095));
      frame_px = eff_dim(DIM_W'(w)) * eff_dim(DIM_W'(h));
      n = (frame_px <= 64) ? frame_px * $urandom_range(1, 2) + $urandom_range(3) :
                             $urandom_range(5, 40);
      queue_pixels(1, 50);
      queue_pixels(n - 1, 3);
      small_count += n;
      phase++;
      wait_drained();
    end

    // tall single-column frame: rows well past the point where the address wraps 21 bits
    set_idling(IDLE_NONE);
    set_frame(MODE_GRADIENT, 16'h0000, 1, 1024, 4095);
    queue_pixels(1, 100);
    queue_pixels(599, 0);
    @(negedge clk);
    hold_req++;
    wait_drained();

    // wide single row through all bars, paused halfway until empty
    set_idling(IDLE_BOTH);
    set_frame(MODE_BARS, 16'h0000, 512, 1, 0);
    queue_pixels(1, 100);
    queue_pixels(255, 0);
    wait_drained();
    queue_pixels(256, 0);
    wait_drained();

    repeat (50) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
